>>> hdl/ddm_pkg.sv
// Shared widths, codes, types and the microcode program of the differential drive mixer.
package ddm_pkg;

    // Timer clock that the compare values are counted in.
    localparam int TIMER_HZ   = 100000;
    localparam int PCT_SCALE  = 100;

    // Field widths.
    localparam int CV_W       = 16;
    localparam int STEER_W    = 17;
    localparam int SC_W       = 8;
    localparam int MSA_W      = 8;
    localparam int PCT_W      = 7;
    localparam int FREQ_W     = 10;
    localparam int EN_W       = 4;
    localparam int TICK_W     = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    // Datapath widths.
    localparam int TH_W       = $clog2(TIMER_HZ + 1);
    localparam int DVD_W      = PCT_W + TH_W;
    localparam int DVSR_W     = FREQ_W + $clog2(PCT_SCALE + 1);
    localparam int WORK_W     = DVD_W + 1;
    localparam int TURN_W     = PCT_W + 1;
    localparam int MIX_W      = CV_W + 2;
    localparam int CNT_W      = $clog2(DVD_W + 1);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SERVO_CENTER    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEER_ANGLE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TURN_SPEED  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DUTY_CYCLE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DUTY_CYCLE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PWM_FREQ        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_ENABLES   = 3'd6;

    // Configuration reset values.
    localparam logic [SC_W-1:0]   RST_SERVO_CENTER    = 8'd90;
    localparam logic [MSA_W-1:0]  RST_MAX_STEER_ANGLE = 8'd45;
    localparam logic [PCT_W-1:0]  RST_MAX_TURN_SPEED  = 7'd50;
    localparam logic [PCT_W-1:0]  RST_MAX_DUTY_CYCLE  = 7'd100;
    localparam logic [PCT_W-1:0]  RST_MIN_DUTY_CYCLE  = 7'd0;
    localparam logic [FREQ_W-1:0] RST_PWM_FREQ        = 10'd50;
    localparam logic [EN_W-1:0]   RST_DRIVE_ENABLES   = 4'd1;

    // Microcode fields.
    localparam int PC_W   = 4;
    localparam int OP_W   = 4;
    localparam int COND_W = 3;

    // Datapath operations.
    localparam logic [OP_W-1:0] OP_NOP    = 4'd0;
    localparam logic [OP_W-1:0] OP_LOAD   = 4'd1;
    localparam logic [OP_W-1:0] OP_CLAMP  = 4'd2;
    localparam logic [OP_W-1:0] OP_MULT   = 4'd3;
    localparam logic [OP_W-1:0] OP_DSTART = 4'd4;
    localparam logic [OP_W-1:0] OP_TTURN  = 4'd5;
    localparam logic [OP_W-1:0] OP_MIX    = 4'd6;
    localparam logic [OP_W-1:0] OP_MAG    = 4'd7;
    localparam logic [OP_W-1:0] OP_SCALE  = 4'd8;
    localparam logic [OP_W-1:0] OP_TTICK  = 4'd9;
    localparam logic [OP_W-1:0] OP_EMIT   = 4'd10;

    // Sequencing conditions.
    localparam logic [COND_W-1:0] C_NEXT     = 3'd0;
    localparam logic [COND_W-1:0] C_WAIT_IN  = 3'd1;
    localparam logic [COND_W-1:0] C_WAIT_DIV = 3'd2;
    localparam logic [COND_W-1:0] C_IF_MSA0  = 3'd3;
    localparam logic [COND_W-1:0] C_WAIT_OUT = 3'd4;

    // Program addresses that are jump targets.
    localparam logic [PC_W-1:0] ADDR_IDLE  = 4'd0;
    localparam logic [PC_W-1:0] ADDR_MIX_L = 4'd5;

    // The alt bit selects the right motor for side operations and the
    // tick divisor for a divide start.
    localparam logic ALT_LEFT  = 1'b0;
    localparam logic ALT_RIGHT = 1'b1;
    localparam logic ALT_STEER = 1'b0;
    localparam logic ALT_TICK  = 1'b1;

    typedef struct packed {
        logic [SC_W-1:0]   servo_center;
        logic [MSA_W-1:0]  max_steer_angle;
        logic [PCT_W-1:0]  max_turn_speed;
        logic [PCT_W-1:0]  max_duty_cycle;
        logic [PCT_W-1:0]  min_duty_cycle;
        logic [FREQ_W-1:0] pwm_freq;
        logic [EN_W-1:0]   drive_enables;
    } t_cfg;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic              alt;
        logic [COND_W-1:0] cond;
        logic [PC_W-1:0]   target;
    } t_uword;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            alt;
        logic            fire;
    } t_ctl;

    typedef struct packed {
        logic in_valid;
        logic div_busy;
        logic msa_zero;
        logic out_free;
    } t_flags;

    typedef struct packed {
        logic              start;
        logic [DVD_W-1:0]  dividend;
        logic [DVSR_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              update;
        logic              set_dir;
        logic              forward;
        logic [TICK_W-1:0] ticks;
    } t_motor;

    function automatic t_uword uw_make(input logic [OP_W-1:0] op, input logic alt,
                                       input logic [COND_W-1:0] cond,
                                       input logic [PC_W-1:0] target);
        t_uword w;
        w.op     = op;
        w.alt    = alt;
        w.cond   = cond;
        w.target = target;
        return w;
    endfunction

    // The program: one control word per step.
    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        unique case (pc)
            4'd0:    w = uw_make(OP_LOAD,   1'b0,      C_WAIT_IN,  ADDR_IDLE);
            4'd1:    w = uw_make(OP_CLAMP,  1'b0,      C_IF_MSA0,  ADDR_MIX_L);
            4'd2:    w = uw_make(OP_MULT,   1'b0,      C_NEXT,     ADDR_IDLE);
            4'd3:    w = uw_make(OP_DSTART, ALT_STEER, C_NEXT,     ADDR_IDLE);
            4'd4:    w = uw_make(OP_TTURN,  1'b0,      C_WAIT_DIV, ADDR_IDLE);
            4'd5:    w = uw_make(OP_MIX,    ALT_LEFT,  C_NEXT,     ADDR_IDLE);
            4'd6:    w = uw_make(OP_MAG,    ALT_LEFT,  C_NEXT,     ADDR_IDLE);
            4'd7:    w = uw_make(OP_SCALE,  ALT_LEFT,  C_NEXT,     ADDR_IDLE);
            4'd8:    w = uw_make(OP_DSTART, ALT_TICK,  C_NEXT,     ADDR_IDLE);
            4'd9:    w = uw_make(OP_TTICK,  ALT_LEFT,  C_WAIT_DIV, ADDR_IDLE);
            4'd10:   w = uw_make(OP_MIX,    ALT_RIGHT, C_NEXT,     ADDR_IDLE);
            4'd11:   w = uw_make(OP_MAG,    ALT_RIGHT, C_NEXT,     ADDR_IDLE);
            4'd12:   w = uw_make(OP_SCALE,  ALT_RIGHT, C_NEXT,     ADDR_IDLE);
            4'd13:   w = uw_make(OP_DSTART, ALT_TICK,  C_NEXT,     ADDR_IDLE);
            4'd14:   w = uw_make(OP_TTICK,  ALT_RIGHT, C_WAIT_DIV, ADDR_IDLE);
            4'd15:   w = uw_make(OP_EMIT,   1'b0,      C_WAIT_OUT, ADDR_IDLE);
            default: w = uw_make(OP_NOP,    1'b0,      C_NEXT,     ADDR_IDLE);
        endcase
        return w;
    endfunction

endpackage

>>> hdl/ddm_useq.sv
// Microcode sequencer: step counter, program table and jump logic.
module ddm_useq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ddm_pkg::t_flags i_flags,
    output ddm_pkg::t_ctl   o_ctl,
    output logic            o_in_ready
);

    logic [ddm_pkg::PC_W-1:0] r_pc;
    logic [ddm_pkg::PC_W-1:0] n_pc;
    ddm_pkg::t_uword          uw;
    logic                     fire;

    assign uw = ddm_pkg::ucode(r_pc);

    always_comb begin
        fire = 1'b0;
        n_pc = r_pc;
        unique case (uw.cond)
            ddm_pkg::C_NEXT: begin
                fire = 1'b1;
                n_pc = r_pc + ddm_pkg::PC_W'(1);
            end
            ddm_pkg::C_WAIT_IN: begin
                fire = i_flags.in_valid;
                n_pc = fire ? r_pc + ddm_pkg::PC_W'(1) : r_pc;
            end
            ddm_pkg::C_WAIT_DIV: begin
                fire = !i_flags.div_busy;
                n_pc = fire ? r_pc + ddm_pkg::PC_W'(1) : r_pc;
            end
            ddm_pkg::C_IF_MSA0: begin
                fire = 1'b1;
                n_pc = i_flags.msa_zero ? uw.target : r_pc + ddm_pkg::PC_W'(1);
            end
            ddm_pkg::C_WAIT_OUT: begin
                fire = i_flags.out_free;
                n_pc = fire ? uw.target : r_pc;
            end
            default: begin
                fire = 1'b0;
                n_pc = ddm_pkg::ADDR_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= ddm_pkg::ADDR_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctl.op    = uw.op;
    assign o_ctl.alt   = uw.alt;
    assign o_ctl.fire  = fire;
    assign o_in_ready  = (uw.cond == ddm_pkg::C_WAIT_IN);

endmodule

>>> hdl/ddm_div.sv
// Restoring unsigned divider that retires one quotient bit per cycle.
module ddm_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  ddm_pkg::t_div_req          i_req,
    output logic                       o_busy,
    output logic [ddm_pkg::DVD_W-1:0]  o_quotient
);

    logic                          r_busy;
    logic [ddm_pkg::CNT_W-1:0]     r_cnt;
    logic [ddm_pkg::DVSR_W-1:0]    r_rem;
    logic [ddm_pkg::DVD_W-1:0]     r_quo;
    logic [ddm_pkg::DVSR_W-1:0]    r_dvsr;
    logic [ddm_pkg::DVSR_W:0]      shifted;
    logic [ddm_pkg::DVSR_W:0]      diff;
    logic                          ge;

    assign shifted = {r_rem, r_quo[ddm_pkg::DVD_W-1]};
    assign diff    = shifted - {1'b0, r_dvsr};
    assign ge      = (shifted >= {1'b0, r_dvsr});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_cnt == ddm_pkg::CNT_W'(1)) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_cnt  <= ddm_pkg::CNT_W'(ddm_pkg::DVD_W);
            r_rem  <= '0;
            r_quo  <= i_req.dividend;
            r_dvsr <= i_req.divisor;
        end else if (r_busy) begin
            r_cnt <= r_cnt - ddm_pkg::CNT_W'(1);
            r_rem <= ge ? diff[ddm_pkg::DVSR_W-1:0] : shifted[ddm_pkg::DVSR_W-1:0];
            r_quo <= {r_quo[ddm_pkg::DVD_W-2:0], ge};
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

>>> hdl/ddm_dpath.sv
// Mixer datapath: drive state, work register, clamps and the result registers.
module ddm_dpath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ddm_pkg::t_ctl                     i_ctl,
    input  ddm_pkg::t_cfg                     i_cfg,
    input  logic signed [ddm_pkg::CV_W-1:0]   i_control_value,
    input  logic                              i_is_steering,
    output ddm_pkg::t_div_req                 o_div_req,
    input  logic [ddm_pkg::DVD_W-1:0]         i_quotient,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output ddm_pkg::t_motor                   o_left,
    output ddm_pkg::t_motor                   o_right
);

    localparam int SC_EXT  = ddm_pkg::STEER_W - ddm_pkg::SC_W;
    localparam int ST_EXT  = ddm_pkg::STEER_W + 1 - ddm_pkg::MSA_W;
    localparam int PR_W    = ddm_pkg::MSA_W + ddm_pkg::PCT_W + 2;
    localparam int MX_EXT  = ddm_pkg::MIX_W - ddm_pkg::PCT_W;
    localparam int WK_EXT  = ddm_pkg::WORK_W - ddm_pkg::PCT_W;
    localparam int DV_EXT  = ddm_pkg::DVSR_W - ddm_pkg::MSA_W;

    logic signed [ddm_pkg::CV_W-1:0]    r_drive, n_drive;
    logic signed [ddm_pkg::STEER_W-1:0] r_steer, n_steer;
    logic signed [ddm_pkg::WORK_W-1:0]  r_a, n_a;
    logic signed [ddm_pkg::TURN_W-1:0]  r_turn, n_turn;
    logic                               r_neg, n_neg;
    logic                               r_qneg, n_qneg;
    ddm_pkg::t_motor                    r_left, n_left;
    ddm_pkg::t_motor                    r_right, n_right;
    ddm_pkg::t_motor                    r_out_l, n_out_l;
    ddm_pkg::t_motor                    r_out_r, n_out_r;
    logic                               r_out_valid, n_out_valid;

    // Helper values for the operations.
    logic signed [ddm_pkg::WORK_W-1:0]   a_mag;
    logic signed [ddm_pkg::STEER_W:0]    st_x, st_lim, st_c;
    logic signed [ddm_pkg::MSA_W+1:0]    mc;
    logic signed [PR_W-1:0]              prod, prod_h;
    logic signed [ddm_pkg::TURN_W-1:0]   tq;
    logic signed [ddm_pkg::MIX_W-1:0]    mx_d, mx_t, mx_s, mx_lim, mx_c;
    logic [ddm_pkg::PCT_W-1:0]           m7;
    logic                                m_small;
    logic [ddm_pkg::DVD_W-1:0]           scaled;
    logic [ddm_pkg::FREQ_W-1:0]          freq_eff;
    logic [ddm_pkg::DVSR_W-1:0]          tick_dvsr;
    logic [ddm_pkg::TICK_W-1:0]          ticks;
    ddm_pkg::t_motor                     mot;

    function automatic ddm_pkg::t_motor motor_calc(input logic [ddm_pkg::TICK_W-1:0] tk,
                                                   input logic neg, input logic fwd_ok,
                                                   input logic rev_ok);
        ddm_pkg::t_motor m;
        logic            use_rev;
        logic            upd;
        use_rev   = rev_ok && neg;
        upd       = use_rev || fwd_ok;
        m.update  = upd;
        m.set_dir = upd && (tk != '0);
        m.forward = upd && (tk != '0) && !use_rev;
        m.ticks   = upd ? tk : '0;
        return m;
    endfunction

    assign a_mag = r_a[ddm_pkg::WORK_W-1] ? -r_a : r_a;

    // Steering offset clamped to plus or minus the steer limit.
    assign st_x   = {r_steer[ddm_pkg::STEER_W-1], r_steer};
    assign st_lim = $signed({{ST_EXT{1'b0}}, i_cfg.max_steer_angle});
    assign st_c   = (st_x > st_lim) ? st_lim : ((st_x < -st_lim) ? -st_lim : st_x);

    // Scaled offset halved with truncation toward zero.
    assign mc     = $signed(r_a[ddm_pkg::MSA_W+1:0]);
    assign prod   = PR_W'(mc) * PR_W'($signed({1'b0, i_cfg.max_turn_speed}));
    assign prod_h = (prod + $signed({{(PR_W-1){1'b0}}, prod[PR_W-1]})) >>> 1;

    assign tq = $signed({1'b0, i_quotient[ddm_pkg::TURN_W-2:0]});

    // Motor sum (left) or difference (right) clamped to plus or minus the duty limit.
    assign mx_d   = ddm_pkg::MIX_W'(r_drive);
    assign mx_t   = ddm_pkg::MIX_W'(r_turn);
    assign mx_s   = (i_ctl.alt == ddm_pkg::ALT_RIGHT) ? mx_d - mx_t : mx_d + mx_t;
    assign mx_lim = $signed({{MX_EXT{1'b0}}, i_cfg.max_duty_cycle});
    assign mx_c   = (mx_s > mx_lim) ? mx_lim : ((mx_s < -mx_lim) ? -mx_lim : mx_s);

    assign m7      = a_mag[ddm_pkg::PCT_W-1:0];
    assign m_small = (m7 < i_cfg.min_duty_cycle);

    assign scaled = {{ddm_pkg::TH_W{1'b0}}, r_a[ddm_pkg::PCT_W-1:0]}
                    * ddm_pkg::DVD_W'(ddm_pkg::TIMER_HZ);

    // Ticks are (mag * TIMER_HZ) / (freq * 100), the same as dividing twice.
    assign freq_eff  = (i_cfg.pwm_freq == '0) ? ddm_pkg::FREQ_W'(1) : i_cfg.pwm_freq;
    assign tick_dvsr = ddm_pkg::DVSR_W'(freq_eff) * ddm_pkg::DVSR_W'(ddm_pkg::PCT_SCALE);

    assign ticks = i_quotient[ddm_pkg::TICK_W-1:0];
    assign mot   = (i_ctl.alt == ddm_pkg::ALT_RIGHT)
                   ? motor_calc(ticks, r_neg, i_cfg.drive_enables[2], i_cfg.drive_enables[3])
                   : motor_calc(ticks, r_neg, i_cfg.drive_enables[0], i_cfg.drive_enables[1]);

    always_comb begin
        n_drive     = r_drive;
        n_steer     = r_steer;
        n_a         = r_a;
        n_turn      = r_turn;
        n_neg       = r_neg;
        n_qneg      = r_qneg;
        n_left      = r_left;
        n_right     = r_right;
        n_out_l     = r_out_l;
        n_out_r     = r_out_r;
        n_out_valid = r_out_valid && !i_out_ready;

        o_div_req.start    = 1'b0;
        o_div_req.dividend = a_mag[ddm_pkg::DVD_W-1:0];
        o_div_req.divisor  = {{DV_EXT{1'b0}}, i_cfg.max_steer_angle};
        if (i_ctl.alt == ddm_pkg::ALT_TICK) begin
            o_div_req.dividend = r_a[ddm_pkg::DVD_W-1:0];
            o_div_req.divisor  = tick_dvsr;
        end

        if (i_ctl.fire) begin
            unique case (i_ctl.op)
                ddm_pkg::OP_LOAD: begin
                    if (i_is_steering) begin
                        n_steer = ddm_pkg::STEER_W'(i_control_value)
                                  - $signed({{SC_EXT{1'b0}}, i_cfg.servo_center});
                    end else begin
                        n_drive = i_control_value;
                    end
                end
                ddm_pkg::OP_CLAMP: begin
                    n_a    = ddm_pkg::WORK_W'(st_c);
                    n_turn = '0;
                end
                ddm_pkg::OP_MULT: begin
                    n_a = ddm_pkg::WORK_W'(prod_h);
                end
                ddm_pkg::OP_DSTART: begin
                    o_div_req.start = 1'b1;
                    n_qneg          = r_a[ddm_pkg::WORK_W-1];
                end
                ddm_pkg::OP_TTURN: begin
                    n_turn = (r_qneg ^ r_drive[ddm_pkg::CV_W-1]) ? -tq : tq;
                end
                ddm_pkg::OP_MIX: begin
                    n_a = ddm_pkg::WORK_W'(mx_c);
                end
                ddm_pkg::OP_MAG: begin
                    n_a   = m_small ? '0 : $signed({{WK_EXT{1'b0}}, m7});
                    n_neg = !m_small && r_a[ddm_pkg::WORK_W-1];
                end
                ddm_pkg::OP_SCALE: begin
                    n_a = $signed({1'b0, scaled});
                end
                ddm_pkg::OP_TTICK: begin
                    if (i_ctl.alt == ddm_pkg::ALT_RIGHT) begin
                        n_right = mot;
                    end else begin
                        n_left = mot;
                    end
                end
                ddm_pkg::OP_EMIT: begin
                    n_out_l     = r_left;
                    n_out_r     = r_right;
                    n_out_valid = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drive     <= '0;
            r_steer     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_drive     <= n_drive;
            r_steer     <= n_steer;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a     <= n_a;
        r_turn  <= n_turn;
        r_neg   <= n_neg;
        r_qneg  <= n_qneg;
        r_left  <= n_left;
        r_right <= n_right;
        r_out_l <= n_out_l;
        r_out_r <= n_out_r;
    end

    assign o_out_valid = r_out_valid;
    assign o_left      = r_out_l;
    assign o_right     = r_out_r;

endmodule

>>> hdl/differential_drive_mixer_top.sv
// Top level of the differential drive mixer: configuration, sequencer, datapath and divider.
//
//   Channel   Direction  Handshake                   Payload
//   input     in         i_in_valid / o_in_ready     i_control_value, i_is_steering
//   result    out        o_out_valid / i_out_ready   o_left_*, o_right_*
//   config    in         i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// The next transfer is taken only once the result of the last item is registered. The
// shared divider runs once for the turn speed, skipped when max_steer_angle is zero, and
// once per motor; each quotient takes one more program step to collect.
// Reset is synchronous and active low; it restores the configuration defaults and clears
// the stored drive speed and steering offset. A finished result sits in an output register,
// and the next input is taken while it waits; the result channel only stalls the program at
// its last step if the previous result has still not been taken.
module differential_drive_mixer_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Input channel.
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic signed [ddm_pkg::CV_W-1:0]      i_control_value,
    input  logic                                 i_is_steering,
    // Result channel.
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic                                 o_left_update,
    output logic                                 o_left_set_dir,
    output logic                                 o_left_forward,
    output logic [ddm_pkg::TICK_W-1:0]           o_left_ticks,
    output logic                                 o_right_update,
    output logic                                 o_right_set_dir,
    output logic                                 o_right_forward,
    output logic [ddm_pkg::TICK_W-1:0]           o_right_ticks,
    // Configuration write channel.
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [ddm_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [ddm_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    ddm_pkg::t_cfg     r_cfg;
    ddm_pkg::t_flags   flags;
    ddm_pkg::t_ctl     ctl;
    ddm_pkg::t_div_req div_req;
    ddm_pkg::t_motor   left_m;
    ddm_pkg::t_motor   right_m;
    logic                             div_busy;
    logic [ddm_pkg::DVD_W-1:0]        quotient;
    logic                             cfg_xfer;

    // Configuration writes are always taken; an index past the last register is dropped.
    assign o_cfg_ready = 1'b1;
    assign cfg_xfer    = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.servo_center    <= ddm_pkg::RST_SERVO_CENTER;
            r_cfg.max_steer_angle <= ddm_pkg::RST_MAX_STEER_ANGLE;
            r_cfg.max_turn_speed  <= ddm_pkg::RST_MAX_TURN_SPEED;
            r_cfg.max_duty_cycle  <= ddm_pkg::RST_MAX_DUTY_CYCLE;
            r_cfg.min_duty_cycle  <= ddm_pkg::RST_MIN_DUTY_CYCLE;
            r_cfg.pwm_freq        <= ddm_pkg::RST_PWM_FREQ;
            r_cfg.drive_enables   <= ddm_pkg::RST_DRIVE_ENABLES;
        end else if (cfg_xfer) begin
            unique case (i_cfg_index)
                ddm_pkg::CFG_SERVO_CENTER:
                    r_cfg.servo_center <= i_cfg_data[ddm_pkg::SC_W-1:0];
                ddm_pkg::CFG_MAX_STEER_ANGLE:
                    r_cfg.max_steer_angle <= i_cfg_data[ddm_pkg::MSA_W-1:0];
                ddm_pkg::CFG_MAX_TURN_SPEED:
                    r_cfg.max_turn_speed <= i_cfg_data[ddm_pkg::PCT_W-1:0];
                ddm_pkg::CFG_MAX_DUTY_CYCLE:
                    r_cfg.max_duty_cycle <= i_cfg_data[ddm_pkg::PCT_W-1:0];
                ddm_pkg::CFG_MIN_DUTY_CYCLE:
                    r_cfg.min_duty_cycle <= i_cfg_data[ddm_pkg::PCT_W-1:0];
                ddm_pkg::CFG_PWM_FREQ:
                    r_cfg.pwm_freq <= i_cfg_data[ddm_pkg::FREQ_W-1:0];
                ddm_pkg::CFG_DRIVE_ENABLES:
                    r_cfg.drive_enables <= i_cfg_data[ddm_pkg::EN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Conditions the program branches and waits on.
    assign flags.in_valid = i_in_valid;
    assign flags.div_busy = div_busy;
    assign flags.msa_zero = (r_cfg.max_steer_angle == '0);
    assign flags.out_free = !o_out_valid || i_out_ready;

    ddm_useq u_useq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_flags    (flags),
        .o_ctl      (ctl),
        .o_in_ready (o_in_ready)
    );

    ddm_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (ctl),
        .i_cfg           (r_cfg),
        .i_control_value (i_control_value),
        .i_is_steering   (i_is_steering),
        .o_div_req       (div_req),
        .i_quotient      (quotient),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_left          (left_m),
        .o_right         (right_m)
    );

    ddm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .o_busy     (div_busy),
        .o_quotient (quotient)
    );

    assign o_left_update   = left_m.update;
    assign o_left_set_dir  = left_m.set_dir;
    assign o_left_forward  = left_m.forward;
    assign o_left_ticks    = left_m.ticks;
    assign o_right_update  = right_m.update;
    assign o_right_set_dir = right_m.set_dir;
    assign o_right_forward = right_m.forward;
    assign o_right_ticks   = right_m.ticks;

`ifndef SYNTHESIS
    // The divider is never restarted while a division is still running.
    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> !div_busy)
        else $error("divider started while busy");

    // After an input transfer the block works on that item and takes no other.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second input taken while an item is in progress");

    // A direction write needs an update with a nonzero compare value.
    a_left_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_left_set_dir) |-> (o_left_update && o_left_ticks != '0))
        else $error("left direction written without a speed update");

    a_right_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_right_set_dir) |-> (o_right_update && o_right_ticks != '0))
        else $error("right direction written without a speed update");
`endif

endmodule
